// ----- rtl/pwra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCIe write request arbiter package
// Source codes, arbiter modes and the request word layouts.
// ----------------------------------------------------------------------------
package pwra_pkg;

  // Source codes as reported on header_taken and beat_taken.
  localparam logic [2:0] SRC_NONE      = 3'd0;
  localparam logic [2:0] SRC_HOST_DATA = 3'd1;
  localparam logic [2:0] SRC_RD_FIN    = 3'd2;
  localparam logic [2:0] SRC_WR_FIN    = 3'd3;
  localparam logic [2:0] SRC_RD_DEV    = 3'd4;
  localparam logic [2:0] SRC_WR_DEV    = 3'd5;

  // Bit positions in the header, beat valid and beat last masks.
  localparam int unsigned BIT_HOST_DATA = 0;
  localparam int unsigned BIT_RD_FIN    = 1;
  localparam int unsigned BIT_WR_FIN    = 2;
  localparam int unsigned BIT_RD_DEV    = 3;
  localparam int unsigned BIT_WR_DEV    = 4;

  localparam int unsigned NUM_SRC   = 5;
  localparam int unsigned BEATS_W   = 8;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_HOST_DATA = 3'd1,
    MODE_RD_FIN    = 3'd2,
    MODE_WR_FIN    = 3'd3,
    MODE_RD_DEV    = 3'd4,
    MODE_WR_DEV    = 3'd5,
    MODE_WAIT_RD_FIN = 3'd6
  } mode_t;

endpackage

// ----- rtl/pcie_write_request_arbiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCIe write request arbiter
// Fixed priority header grant with packet lock over five write sources.
// ----------------------------------------------------------------------------
// Each input request carries a snapshot of the five header and data queue
// heads; each one yields exactly one result request naming the header and the
// data beat popped in that tick. The arbiter takes one request per cycle while
// the output register is free or being taken: the request is captured in an
// input register, the grant and beat decisions are made in one short pass
// against the mode and beat count registers, and the result lands in an
// output register. The input side keeps accepting while a result waits, as
// long as the output register is taken in the same cycle.
module pcie_write_request_arbiter
  import pwra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // [4:0] header_valid, [9:5] beat_valid, [14:10] beat_last,
  // [22:15] read_device_beats, [30:23] write_device_beats, [31] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] header_taken, [5:3] beat_taken, [7:6] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,   // beat_out_last
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  // Input register.
  logic                 in_vld_r;
  logic [NUM_SRC-1:0]   hv_r, bv_r, bl_r;
  logic [BEATS_W-1:0]   rd_beats_r, wr_beats_r;

  // Arbiter state.
  mode_t                mode_r, mode_nxt;
  logic [BEATS_W-1:0]   beats_r, beats_nxt;

  // Output register.
  logic                 out_vld_r;
  logic [2:0]           hdr_out_r, beat_out_r;
  logic                 last_out_r;

  // Header stage results.
  logic [2:0]           hdr;
  mode_t                mode_eff;
  logic [BEATS_W-1:0]   beats_eff;

  // Data stage results.
  logic [2:0]           beat;
  logic                 last;
  logic                 src_bv, src_bl;
  logic                 is_dev;

  logic                 advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  // Header grant by fixed priority when idle; only read-finish while waiting for it.
  always_comb begin
    hdr       = SRC_NONE;
    mode_eff  = mode_r;
    beats_eff = beats_r;
    case (mode_r)
      MODE_WAIT_RD_FIN: begin
        if (hv_r[BIT_RD_FIN]) begin
          hdr      = SRC_RD_FIN;
          mode_eff = MODE_RD_FIN;
        end
      end
      MODE_HOST_DATA, MODE_RD_FIN, MODE_WR_FIN, MODE_RD_DEV, MODE_WR_DEV: begin
        mode_eff = mode_r;
      end
      default: begin
        // Idle; the unused mode code behaves exactly like idle.
        mode_eff = MODE_IDLE;
        if (hv_r[BIT_WR_FIN]) begin
          hdr      = SRC_WR_FIN;
          mode_eff = MODE_WR_FIN;
        end else if (hv_r[BIT_HOST_DATA]) begin
          hdr      = SRC_HOST_DATA;
          mode_eff = MODE_HOST_DATA;
        end else if (hv_r[BIT_RD_DEV]) begin
          hdr       = SRC_RD_DEV;
          mode_eff  = MODE_RD_DEV;
          beats_eff = rd_beats_r;
        end else if (hv_r[BIT_WR_DEV]) begin
          hdr       = SRC_WR_DEV;
          mode_eff  = MODE_WR_DEV;
          beats_eff = wr_beats_r;
        end
      end
    endcase
  end

  // Beat forwarding for the source that holds the lock.
  always_comb begin
    src_bv = 1'b0;
    src_bl = 1'b0;
    is_dev = 1'b0;
    case (mode_eff)
      MODE_HOST_DATA: begin
        src_bv = bv_r[BIT_HOST_DATA];
        src_bl = bl_r[BIT_HOST_DATA];
      end
      MODE_RD_FIN: begin
        src_bv = bv_r[BIT_RD_FIN];
        src_bl = bl_r[BIT_RD_FIN];
      end
      MODE_WR_FIN: begin
        src_bv = bv_r[BIT_WR_FIN];
        src_bl = bl_r[BIT_WR_FIN];
      end
      MODE_RD_DEV: begin
        src_bv = bv_r[BIT_RD_DEV];
        src_bl = bl_r[BIT_RD_DEV];
        is_dev = 1'b1;
      end
      MODE_WR_DEV: begin
        src_bv = bv_r[BIT_WR_DEV];
        src_bl = bl_r[BIT_WR_DEV];
        is_dev = 1'b1;
      end
      default: begin
        src_bv = 1'b0;
      end
    endcase
    beat = src_bv ? mode_eff : SRC_NONE;
    last = src_bv && (src_bl || (is_dev && beats_eff == BEATS_W'(1)));
  end

  // Next mode and beat count.
  always_comb begin
    mode_nxt  = mode_eff;
    beats_nxt = beats_eff;
    if (src_bv) begin
      if (is_dev) begin
        beats_nxt = beats_eff - BEATS_W'(1);
        if (beats_eff == BEATS_W'(1)) begin
          mode_nxt = MODE_IDLE;
        end
      end else if (src_bl) begin
        // A host data packet always hands over to the read-finish header.
        mode_nxt = (mode_eff == MODE_HOST_DATA) ? MODE_WAIT_RD_FIN : MODE_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r    <= MODE_IDLE;
      beats_r   <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        mode_r    <= mode_nxt;
        beats_r   <= beats_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      hv_r       <= in_tdata[4:0];
      bv_r       <= in_tdata[9:5];
      bl_r       <= in_tdata[14:10];
      rd_beats_r <= in_tdata[22:15];
      wr_beats_r <= in_tdata[30:23];
    end
    if (advance) begin
      hdr_out_r  <= hdr;
      beat_out_r <= beat;
      last_out_r <= last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, beat_out_r, hdr_out_r};
  assign out_tlast  = last_out_r;

  // A stalled input register means a result is waiting on the output side.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_vld_r)
    else $error("input stalled without a pending result");

  // The last flag only accompanies a forwarded beat.
  a_last_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && beat_out_r == SRC_NONE |-> !last_out_r)
    else $error("last flag without a beat");

  // While waiting for read-finish only that header may be granted.
  a_wait_grant: assert property (@(posedge clk) disable iff (!rst_n)
    advance && mode_r == MODE_WAIT_RD_FIN |=> hdr_out_r == SRC_NONE ||
      hdr_out_r == SRC_RD_FIN)
    else $error("wrong header granted while waiting for read-finish");

endmodule
